@@ src/lc2k_pkg.sv @@
// Shared constants and types for the LC-2K instruction executor.
// Item op codes, instruction opcodes, memory geometry and shared-ALU request type.
// No dependencies.
`default_nettype none

package lc2k_pkg;

	// Word memory geometry: addresses wrap at a power of two
	localparam int MEM_AW    = 16;
	localparam int MEM_WORDS = 1 << MEM_AW;

	// Register file geometry
	localparam int NUM_REGS = 8;
	localparam int RF_AW    = $clog2(NUM_REGS);

	localparam int WORD_W = 32;

	// Item op codes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_EXEC  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Instruction opcodes (bits 24..22)
	localparam logic [2:0] OPC_ADD  = 3'd0;
	localparam logic [2:0] OPC_NOR  = 3'd1;
	localparam logic [2:0] OPC_LW   = 3'd2;
	localparam logic [2:0] OPC_SW   = 3'd3;
	localparam logic [2:0] OPC_BEQ  = 3'd4;
	localparam logic [2:0] OPC_JALR = 3'd5;
	localparam logic [2:0] OPC_HALT = 3'd6;
	localparam logic [2:0] OPC_NOOP = 3'd7;

	// Shared ALU functions
	localparam logic [1:0] ALU_ADD = 2'd0;
	localparam logic [1:0] ALU_NOR = 2'd1;
	localparam logic [1:0] ALU_EQ  = 2'd2;

	typedef struct packed {
		logic [1:0]        func;
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
	} alu_req_t;

endpackage

`default_nettype wire

@@ src/lc2k_instruction_executor.sv @@
// Top level of the LC-2K instruction executor: sequencer, state registers and result beat.
// Depends on lc2k_pkg, lc2k_ram (word memory and register file) and lc2k_alu.
`default_nettype none

// LC-2K processor driven one item at a time. Each input beat is a memory write
// (op 0), one executed instruction (op 1, a plain read while halted) or a plain
// read (op 2 or 3), and each returns one result beat with pc, halt flag,
// executed count, the selected register and the memory word at the given
// address. The block takes one item at a time and is not ready while it works;
// its sequence is set by the single-port word memory and single-port register
// file, which serialize fetch, operand reads, data access and the two result
// reads, and by the one shared ALU that handles pc increment, count, operation
// and branch target in turn. The register file clears at reset through valid
// bits; the word memory is not cleared, and reading a never-written word
// returns unspecified data. A new item may be accepted while the previous
// result still waits; its result is held back until that beat is taken.
module lc2k_instruction_executor import lc2k_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// [1:0] op, [17:2] address, [49:18] data, [52:50] reg_select, [55:53] zero
	input  wire  [55:0]  s_tdata,
	output logic         m_tvalid,
	input  wire          m_tready,
	// [15:0] pc_value, [16] halted, [48:17] executed_count, [80:49] reg_value,
	// [112:81] mem_value, [119:113] zero
	output logic [119:0] m_tdata
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_WMEM  = 4'd1;
	localparam logic [3:0] S_FETCH = 4'd2;
	localparam logic [3:0] S_DEC   = 4'd3;
	localparam logic [3:0] S_RA    = 4'd4;
	localparam logic [3:0] S_RB    = 4'd5;
	localparam logic [3:0] S_EXEC  = 4'd6;
	localparam logic [3:0] S_LWWB  = 4'd7;
	localparam logic [3:0] S_BR    = 4'd8;
	localparam logic [3:0] S_RREG  = 4'd9;
	localparam logic [3:0] S_RMEM  = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	logic [3:0] state_q;

	// Item fields
	logic [15:0]       addr_q;
	logic [WORD_W-1:0] data_q;
	logic [RF_AW-1:0]  sel_q;

	// Architectural state
	logic [MEM_AW-1:0]   pc_q;
	logic                halt_q;
	logic [WORD_W-1:0]   cnt_q;
	logic [NUM_REGS-1:0] rf_vld_q;

	// Instruction working registers
	logic [WORD_W-1:0] ins_q;
	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	logic [MEM_AW-1:0] next_q;
	logic [WORD_W-1:0] rv_q;
	logic [RF_AW-1:0]  rf_raddr_q;

	// Result beat
	logic              out_vld_q;
	logic [MEM_AW-1:0] out_pc_q;
	logic              out_halt_q;
	logic [WORD_W-1:0] out_cnt_q;
	logic [WORD_W-1:0] out_reg_q;
	logic [WORD_W-1:0] out_mem_q;

	// Memory and register file ports
	logic              mem_en, mem_we;
	logic [MEM_AW-1:0] mem_addr;
	logic [WORD_W-1:0] mem_wdata, mem_rdata;
	logic              rf_en, rf_we;
	logic [RF_AW-1:0]  rf_addr;
	logic [WORD_W-1:0] rf_wdata, rf_rdata, rf_rd;

	alu_req_t          alu_req;
	logic [WORD_W-1:0] alu_res;

	// Decoded instruction fields
	logic [2:0]        opc;
	logic [RF_AW-1:0]  ra, rb, rd;
	logic [WORD_W-1:0] off_ext;
	logic              accept, out_free;

	assign opc     = ins_q[24:22];
	assign ra      = ins_q[21:19];
	assign rb      = ins_q[18:16];
	assign rd      = ins_q[2:0];
	assign off_ext = {{(WORD_W-16){ins_q[15]}}, ins_q[15:0]};

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;

	// Unwritten registers read as zero
	assign rf_rd = rf_vld_q[rf_raddr_q] ? rf_rdata : '0;

	lc2k_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_mem (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	lc2k_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_rf (
		.clk   (clk),
		.en    (rf_en),
		.we    (rf_we),
		.addr  (rf_addr),
		.wdata (rf_wdata),
		.rdata (rf_rdata)
	);

	lc2k_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	// Drive memory, register file and ALU for the current step
	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = pc_q;
		mem_wdata = b_q;
		rf_en     = 1'b0;
		rf_we     = 1'b0;
		rf_addr   = sel_q;
		rf_wdata  = alu_res;
		alu_req.func = ALU_ADD;
		alu_req.x    = a_q;
		alu_req.y    = b_q;
		case (state_q)
			S_WMEM: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = addr_q[MEM_AW-1:0];
				mem_wdata = data_q;
			end
			S_FETCH: begin
				mem_en    = 1'b1;
				mem_addr  = pc_q;
				alu_req.x = {{(WORD_W-MEM_AW){1'b0}}, pc_q};
				alu_req.y = {{(WORD_W-1){1'b0}}, 1'b1};
			end
			S_DEC: begin
				rf_en     = 1'b1;
				rf_addr   = mem_rdata[21:19];
				alu_req.x = cnt_q;
				alu_req.y = {{(WORD_W-1){1'b0}}, 1'b1};
			end
			S_RA: begin
				rf_en   = 1'b1;
				rf_addr = rb;
			end
			S_EXEC: begin
				case (opc)
					OPC_ADD: begin
						rf_en   = 1'b1;
						rf_we   = 1'b1;
						rf_addr = rd;
					end
					OPC_NOR: begin
						alu_req.func = ALU_NOR;
						rf_en        = 1'b1;
						rf_we        = 1'b1;
						rf_addr      = rd;
					end
					OPC_LW: begin
						alu_req.y = off_ext;
						mem_en    = 1'b1;
						mem_addr  = alu_res[MEM_AW-1:0];
					end
					OPC_SW: begin
						alu_req.y = off_ext;
						mem_en    = 1'b1;
						mem_we    = 1'b1;
						mem_addr  = alu_res[MEM_AW-1:0];
						mem_wdata = b_q;
					end
					OPC_BEQ: begin
						alu_req.func = ALU_EQ;
					end
					OPC_JALR: begin
						rf_en    = 1'b1;
						rf_we    = 1'b1;
						rf_addr  = rb;
						rf_wdata = {{(WORD_W-MEM_AW){1'b0}}, next_q};
					end
					default: begin
					end
				endcase
			end
			S_LWWB: begin
				rf_en    = 1'b1;
				rf_we    = 1'b1;
				rf_addr  = rb;
				rf_wdata = mem_rdata;
			end
			S_BR: begin
				alu_req.x = {{(WORD_W-MEM_AW){1'b0}}, next_q};
				alu_req.y = off_ext;
			end
			S_RREG: begin
				rf_en   = 1'b1;
				rf_addr = sel_q;
			end
			S_RMEM: begin
				mem_en   = 1'b1;
				mem_addr = addr_q[MEM_AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pc_q     <= '0;
			halt_q   <= 1'b0;
			cnt_q    <= '0;
			rf_vld_q <= '0;
		end else begin
			// Mark registers once written
			if (rf_en && rf_we) begin
				rf_vld_q[rf_addr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_tdata[1:0] == OP_WRITE) begin
							state_q <= S_WMEM;
						end else if (s_tdata[1:0] == OP_EXEC && !halt_q) begin
							state_q <= S_FETCH;
						end else begin
							state_q <= S_RREG;
						end
					end
				end
				S_WMEM:  state_q <= S_RREG;
				S_FETCH: state_q <= S_DEC;
				S_DEC: begin
					// Saturating executed count
					if (cnt_q != '1) begin
						cnt_q <= alu_res;
					end
					state_q <= S_RA;
				end
				S_RA: state_q <= S_RB;
				S_RB: begin
					pc_q    <= next_q;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					case (opc)
						OPC_LW: state_q <= S_LWWB;
						OPC_BEQ: begin
							state_q <= alu_res[0] ? S_BR : S_RREG;
						end
						OPC_JALR: begin
							// regB is written first, so equal fields jump to next
							pc_q    <= (ra == rb) ? next_q : a_q[MEM_AW-1:0];
							state_q <= S_RREG;
						end
						OPC_HALT: begin
							halt_q  <= 1'b1;
							state_q <= S_RREG;
						end
						default: state_q <= S_RREG;
					endcase
				end
				S_LWWB: state_q <= S_RREG;
				S_BR: begin
					pc_q    <= alu_res[MEM_AW-1:0];
					state_q <= S_RREG;
				end
				S_RREG: state_q <= S_RMEM;
				S_RMEM: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture item fields and working values
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= s_tdata[17:2];
			data_q <= s_tdata[49:18];
			sel_q  <= s_tdata[52:50];
		end
		if (rf_en && !rf_we) begin
			rf_raddr_q <= rf_addr;
		end
		case (state_q)
			S_FETCH: next_q <= alu_res[MEM_AW-1:0];
			S_DEC:   ins_q  <= mem_rdata;
			S_RA:    a_q    <= rf_rd;
			S_RB:    b_q    <= rf_rd;
			S_RMEM:  rv_q   <= rf_rd;
			default: begin
			end
		endcase
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_pc_q   <= pc_q;
			out_halt_q <= halt_q;
			out_cnt_q  <= cnt_q;
			out_reg_q  <= rv_q;
			out_mem_q  <= mem_rdata;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, out_mem_q, out_reg_q, out_cnt_q, out_halt_q, 16'(out_pc_q)};

endmodule

`default_nettype wire

@@ src/lc2k_ram.sv @@
// Generic single-port RAM with registered read data.
// One write or one read per cycle; read data holds until the next read.
// No dependencies.
`default_nettype none

module lc2k_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire                     clk,
	input  wire                     en,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] addr,
	input  wire [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write or read one word
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ src/lc2k_alu.sv @@
// Shared arithmetic unit of the LC-2K executor: add, nor and equality compare.
// Depends on lc2k_pkg.
`default_nettype none

module lc2k_alu import lc2k_pkg::*; (
	input  wire alu_req_t      req,
	output logic [WORD_W-1:0]  res
);

	// Select the function requested by the sequencer
	always_comb begin
		case (req.func)
			ALU_ADD: res = req.x + req.y;
			ALU_NOR: res = ~(req.x | req.y);
			ALU_EQ:  res = {{(WORD_W-1){1'b0}}, req.x == req.y};
			default: res = '0;
		endcase
	end

endmodule

`default_nettype wire
